// File: rtl/core/parallel_parking_sequencer_macros.svh
// Assertion macros for the parallel parking sequencer.
`ifndef PARALLEL_PARKING_SEQUENCER_MACROS_SVH
`define PARALLEL_PARKING_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge, idle while reset is asserted.
`define PPS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define PPS_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PPS_ASSERT(name, clk, rst_n, prop, msg)
`define PPS_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: rtl/core/pps_pkg.sv
// Types and constants shared by the parallel parking sequencer files.
package pps_pkg;

	localparam int unsigned PATH_W     = 24;
	localparam int unsigned DIST_W     = 11;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned RANGE_W    = 10;
	localparam int unsigned TICK_W     = 8;
	localparam int unsigned SPEED_W    = 3;
	localparam int unsigned STEER_W    = 6;
	localparam int unsigned MPHASE_W   = 4;
	localparam int unsigned SPHASE_W   = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		MV_FORWARD   = 3'd0,
		MV_ALIGN     = 3'd1,
		MV_FRONTTURN = 3'd2,
		MV_HALT      = 3'd3,
		MV_REVERSE   = 3'd4,
		MV_BACKTURN  = 3'd5,
		MV_ADJUST    = 3'd6,
		MV_STOP      = 3'd7
	} move_state_t;

	typedef enum logic [1:0] {
		MS_DETECT   = 2'd0,
		MS_GAP      = 2'd1,
		MS_REAR     = 2'd2,
		MS_DISABLED = 2'd3
	} measure_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_GAP_WIDTH      = 3'd0,
		REG_MIN_GAP_LENGTH     = 3'd1,
		REG_NOISE_TICKS        = 3'd2,
		REG_REAR_SAFE_DISTANCE = 3'd3,
		REG_ALIGN_LENGTH       = 3'd4,
		REG_FRONT_TURN_LENGTH  = 3'd5,
		REG_REVERSE_LENGTH     = 3'd6,
		REG_BACK_TURN_LENGTH   = 3'd7
	} cfg_reg_t;

	localparam logic [RANGE_W-1:0] RST_MIN_GAP_WIDTH      = 10'd25;
	localparam logic [LEN_W-1:0]   RST_MIN_GAP_LENGTH     = 16'd768;
	localparam logic [TICK_W-1:0]  RST_NOISE_TICKS        = 8'd2;
	localparam logic [RANGE_W-1:0] RST_REAR_SAFE_DISTANCE = 10'd3;
	localparam logic [LEN_W-1:0]   RST_ALIGN_LENGTH       = 16'd512;
	localparam logic [LEN_W-1:0]   RST_FRONT_TURN_LENGTH  = 16'd768;
	localparam logic [LEN_W-1:0]   RST_REVERSE_LENGTH     = 16'd1792;
	localparam logic [LEN_W-1:0]   RST_BACK_TURN_LENGTH   = 16'd768;

	localparam logic [TICK_W-1:0]  HALT_TICKS    = 8'd30;
	localparam logic [TICK_W-1:0]  TICK_MAX      = 8'd255;
	localparam logic [PATH_W-1:0]  ADJUST_LENGTH = 24'd256;

	localparam logic signed [STEER_W-1:0] STEER_TURN = -6'sd25;
	localparam logic signed [STEER_W-1:0] STEER_ZERO = 6'sd0;

	localparam logic signed [SPEED_W-1:0] SPEED_FAST = 3'sd3;
	localparam logic signed [SPEED_W-1:0] SPEED_TURN = 3'sd2;
	localparam logic signed [SPEED_W-1:0] SPEED_SLOW = 3'sd1;
	localparam logic signed [SPEED_W-1:0] SPEED_ZERO = 3'sd0;
	localparam logic signed [SPEED_W-1:0] SPEED_BACK = -3'sd2;

endpackage

// File: rtl/core/pps_channels.sv
// Valid/ready channel interfaces for sensor ticks and drive commands.
interface pps_item_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pps_pkg::DIST_W-1:0]    side_distance;
	logic signed [pps_pkg::DIST_W-1:0]    rear_distance;
	logic        [pps_pkg::PATH_W-1:0]    odometer;

	modport source (output valid, side_distance, rear_distance, odometer, input ready);
	modport sink   (input valid, side_distance, rear_distance, odometer, output ready);
endinterface

interface pps_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pps_pkg::SPEED_W-1:0]   speed_half_units;
	logic signed [pps_pkg::STEER_W-1:0]   steering_degrees;
	logic        [pps_pkg::MPHASE_W-1:0]  move_phase;
	logic        [pps_pkg::SPHASE_W-1:0]  measure_phase;

	modport source (output valid, speed_half_units, steering_degrees, move_phase, measure_phase,
		input ready);
	modport sink   (input valid, speed_half_units, steering_degrees, move_phase, measure_phase,
		output ready);
endinterface

// File: rtl/core/parallel_parking_sequencer.sv
// Parallel parking sequencer: gap measuring and parking maneuver state machines.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------------
//  item     | in  | valid/ready    | side_distance, rear_distance, odometer
//  result   | out | valid/ready    | speed_half_units, steering_degrees, phases
//  cfg      | in  | cfg_we         | cfg_index, cfg_data
//
// One tick per cycle sustained while result is ready.
// Input register, then one pass of compare/subtract logic into the state and result registers.
// Result stalls back up into the input register; ready drops only when both are full.
// arst_n sets the configuration registers to defaults, both machines to their first states.
`include "parallel_parking_sequencer_macros.svh"

module parallel_parking_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0]       cfg_data,
	pps_item_if.sink                             item,
	pps_result_if.source                         result
);

	// configuration
	logic [pps_pkg::RANGE_W-1:0] min_gap_width_q;
	logic [pps_pkg::LEN_W-1:0]   min_gap_length_q;
	logic [pps_pkg::TICK_W-1:0]  noise_ticks_q;
	logic [pps_pkg::RANGE_W-1:0] rear_safe_distance_q;
	logic [pps_pkg::LEN_W-1:0]   align_length_q;
	logic [pps_pkg::LEN_W-1:0]   front_turn_length_q;
	logic [pps_pkg::LEN_W-1:0]   reverse_length_q;
	logic [pps_pkg::LEN_W-1:0]   back_turn_length_q;

	// input stage
	logic                               valid_s1;
	logic signed [pps_pkg::DIST_W-1:0]  side_s1;
	logic signed [pps_pkg::DIST_W-1:0]  rear_s1;
	logic [pps_pkg::PATH_W-1:0]         odo_s1;

	// state
	pps_pkg::move_state_t               move_q, move_mid, move_n;
	pps_pkg::measure_state_t            measure_q, measure_mid, measure_n;
	logic [pps_pkg::PATH_W-1:0]         leg_start_q, leg_start_n;
	logic [pps_pkg::TICK_W-1:0]         tick_q, tick_mid, tick_n, tick_halt;

	// result stage
	logic                               out_valid_q;
	logic signed [pps_pkg::SPEED_W-1:0] speed_q, speed_n;
	logic signed [pps_pkg::STEER_W-1:0] steer_q, steer_n;

	logic                               advance;
	logic [pps_pkg::PATH_W-1:0]         leg_dist, dist_mv, leg_len;
	logic                               obstacle, free_side, rear_close;
	logic                               leg_set_ms, leg_set_mv, leg_go;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_width_q      <= pps_pkg::RST_MIN_GAP_WIDTH;
			min_gap_length_q     <= pps_pkg::RST_MIN_GAP_LENGTH;
			noise_ticks_q        <= pps_pkg::RST_NOISE_TICKS;
			rear_safe_distance_q <= pps_pkg::RST_REAR_SAFE_DISTANCE;
			align_length_q       <= pps_pkg::RST_ALIGN_LENGTH;
			front_turn_length_q  <= pps_pkg::RST_FRONT_TURN_LENGTH;
			reverse_length_q     <= pps_pkg::RST_REVERSE_LENGTH;
			back_turn_length_q   <= pps_pkg::RST_BACK_TURN_LENGTH;
		end else if (cfg_we) begin
			unique case (pps_pkg::cfg_reg_t'(cfg_index))
				pps_pkg::REG_MIN_GAP_WIDTH:      min_gap_width_q <= cfg_data[pps_pkg::RANGE_W-1:0];
				pps_pkg::REG_MIN_GAP_LENGTH:     min_gap_length_q <= cfg_data;
				pps_pkg::REG_NOISE_TICKS:        noise_ticks_q <= cfg_data[pps_pkg::TICK_W-1:0];
				pps_pkg::REG_REAR_SAFE_DISTANCE: begin
					rear_safe_distance_q <= cfg_data[pps_pkg::RANGE_W-1:0];
				end
				pps_pkg::REG_ALIGN_LENGTH:       align_length_q <= cfg_data;
				pps_pkg::REG_FRONT_TURN_LENGTH:  front_turn_length_q <= cfg_data;
				pps_pkg::REG_REVERSE_LENGTH:     reverse_length_q <= cfg_data;
				pps_pkg::REG_BACK_TURN_LENGTH:   back_turn_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			side_s1 <= item.side_distance;
			rear_s1 <= item.rear_distance;
			odo_s1  <= item.odometer;
		end
	end

	// measuring machine, first on each tick
	assign leg_dist   = odo_s1 - leg_start_q;
	assign obstacle   = !side_s1[pps_pkg::DIST_W-1] &&
		(side_s1[pps_pkg::RANGE_W-1:0] < min_gap_width_q);
	assign free_side  = side_s1[pps_pkg::DIST_W-1] ||
		(side_s1[pps_pkg::RANGE_W-1:0] > min_gap_width_q);
	assign rear_close = rear_s1[pps_pkg::DIST_W-1] ||
		(rear_s1[pps_pkg::RANGE_W-1:0] <= rear_safe_distance_q);

	always_comb begin
		measure_mid = measure_q;
		move_mid    = move_q;
		tick_mid    = tick_q;
		leg_set_ms  = 1'b0;
		unique case (measure_q)
			pps_pkg::MS_DETECT: begin
				if (free_side) begin
					measure_mid = pps_pkg::MS_GAP;
					leg_set_ms  = 1'b1;
				end
			end
			pps_pkg::MS_GAP: begin
				if (obstacle && (tick_q > noise_ticks_q)) begin
					measure_mid = pps_pkg::MS_DETECT;
				end else if (obstacle) begin
					tick_mid = (tick_q == pps_pkg::TICK_MAX) ? tick_q : tick_q + 1'b1;
				end else if (leg_dist >=
					{{(pps_pkg::PATH_W-pps_pkg::LEN_W){1'b0}}, min_gap_length_q}) begin
					measure_mid = pps_pkg::MS_DISABLED;
					move_mid    = pps_pkg::MV_ALIGN;
					leg_set_ms  = 1'b1;
					tick_mid    = '0;
				end
			end
			pps_pkg::MS_REAR: begin
				if (rear_close) begin
					move_mid    = pps_pkg::MV_ADJUST;
					measure_mid = pps_pkg::MS_DISABLED;
				end
			end
			pps_pkg::MS_DISABLED: ;
			default: ;
		endcase
	end

	// moving machine; a leg started this tick has covered no distance yet
	assign dist_mv = leg_set_ms ? '0 : leg_dist;

	always_comb begin
		leg_len = '0;
		case (move_mid)
			pps_pkg::MV_ALIGN:     leg_len = {{(pps_pkg::PATH_W-pps_pkg::LEN_W){1'b0}}, align_length_q};
			pps_pkg::MV_FRONTTURN: begin
				leg_len = {{(pps_pkg::PATH_W-pps_pkg::LEN_W){1'b0}}, front_turn_length_q};
			end
			pps_pkg::MV_REVERSE:   leg_len = {{(pps_pkg::PATH_W-pps_pkg::LEN_W){1'b0}}, reverse_length_q};
			pps_pkg::MV_BACKTURN:  begin
				leg_len = {{(pps_pkg::PATH_W-pps_pkg::LEN_W){1'b0}}, back_turn_length_q};
			end
			pps_pkg::MV_ADJUST:    leg_len = pps_pkg::ADJUST_LENGTH;
			default:               leg_len = '0;
		endcase
	end

	assign leg_go    = dist_mv <= leg_len;
	assign tick_halt = (tick_mid == pps_pkg::TICK_MAX) ? tick_mid : tick_mid + 1'b1;

	always_comb begin
		move_n     = move_mid;
		measure_n  = measure_mid;
		tick_n     = tick_mid;
		leg_set_mv = 1'b0;
		unique case (move_mid)
			pps_pkg::MV_ALIGN: begin
				if (!leg_go) begin
					move_n     = pps_pkg::MV_FRONTTURN;
					leg_set_mv = 1'b1;
				end
			end
			pps_pkg::MV_FRONTTURN: begin
				if (!leg_go) begin
					move_n     = pps_pkg::MV_HALT;
					leg_set_mv = 1'b1;
				end
			end
			pps_pkg::MV_HALT: begin
				tick_n = tick_halt;
				if (tick_halt >= pps_pkg::HALT_TICKS) begin
					move_n     = pps_pkg::MV_REVERSE;
					leg_set_mv = 1'b1;
					tick_n     = '0;
				end
			end
			pps_pkg::MV_REVERSE: begin
				if (!leg_go) begin
					move_n     = pps_pkg::MV_BACKTURN;
					leg_set_mv = 1'b1;
				end
			end
			pps_pkg::MV_BACKTURN: begin
				measure_n = pps_pkg::MS_REAR;
				if (!leg_go) begin
					move_n     = pps_pkg::MV_ADJUST;
					measure_n  = pps_pkg::MS_DISABLED;
					leg_set_mv = 1'b1;
				end
			end
			pps_pkg::MV_ADJUST: begin
				if (!leg_go) begin
					move_n     = pps_pkg::MV_STOP;
					leg_set_mv = 1'b1;
				end
			end
			pps_pkg::MV_FORWARD, pps_pkg::MV_STOP: ;
			default: ;
		endcase
		leg_start_n = (leg_set_ms || leg_set_mv) ? odo_s1 : leg_start_q;
	end

	always_comb begin
		speed_n = pps_pkg::SPEED_ZERO;
		steer_n = pps_pkg::STEER_ZERO;
		unique case (move_mid)
			pps_pkg::MV_FORWARD: speed_n = pps_pkg::SPEED_FAST;
			pps_pkg::MV_ALIGN: begin
				if (leg_go) speed_n = pps_pkg::SPEED_FAST;
			end
			pps_pkg::MV_FRONTTURN: begin
				if (leg_go) begin
					speed_n = pps_pkg::SPEED_TURN;
					steer_n = pps_pkg::STEER_TURN;
				end
			end
			pps_pkg::MV_REVERSE: begin
				if (leg_go) speed_n = pps_pkg::SPEED_BACK;
			end
			pps_pkg::MV_BACKTURN: begin
				if (leg_go) begin
					speed_n = pps_pkg::SPEED_BACK;
					steer_n = pps_pkg::STEER_TURN;
				end
			end
			pps_pkg::MV_ADJUST: begin
				if (leg_go) speed_n = pps_pkg::SPEED_SLOW;
			end
			pps_pkg::MV_HALT, pps_pkg::MV_STOP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_q      <= pps_pkg::MV_FORWARD;
			measure_q   <= pps_pkg::MS_DETECT;
			leg_start_q <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				move_q      <= move_n;
				measure_q   <= measure_n;
				leg_start_q <= leg_start_n;
				tick_q      <= tick_n;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			speed_q <= speed_n;
			steer_q <= steer_n;
		end
	end

	// state registers only move on a result load, so they double as the phase fields
	assign result.valid            = out_valid_q;
	assign result.speed_half_units = speed_q;
	assign result.steering_degrees = steer_q;
	assign result.move_phase       = {1'b0, move_q};
	assign result.measure_phase    = measure_q;

	`PPS_ASSERT(a_rear_only_in_backturn, clk, arst_n, (measure_q != pps_pkg::MS_REAR) || (move_q == pps_pkg::MV_BACKTURN), "rear guard active outside back turn")
	`PPS_ASSERT(a_stop_is_final, clk, arst_n, (move_q == pps_pkg::MV_STOP) |=> (move_q == pps_pkg::MV_STOP), "left stop phase")
	`PPS_ASSERT(a_disabled_holds, clk, arst_n, (measure_q == pps_pkg::MS_DISABLED && move_q != pps_pkg::MV_BACKTURN) |=> (measure_q == pps_pkg::MS_DISABLED), "measuring restarted")
	`PPS_ASSERT(a_advance_loads, clk, arst_n, advance |=> out_valid_q, "result lost after transfer")
	`PPS_ASSERT(a_held_tick_kept, clk, arst_n, (valid_s1 && !advance) |=> valid_s1, "stalled tick dropped")
	`PPS_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> (!out_valid_q && !valid_s1), "pipeline not empty in reset")

endmodule

// File: bench/tb.sv
// Self-checking bench for the parallel parking sequencer: predicted drive commands vs. DUT.
typedef struct packed {
	logic signed [pps_pkg::SPEED_W-1:0]  speed;
	logic signed [pps_pkg::STEER_W-1:0]  steer;
	logic        [pps_pkg::MPHASE_W-1:0] move_phase;
	logic        [pps_pkg::SPHASE_W-1:0] measure_phase;
} drive_cmd_t;

typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

class maneuver_predictor;
	logic [pps_pkg::RANGE_W-1:0] gap_width;
	logic [pps_pkg::LEN_W-1:0]   gap_length;
	logic [pps_pkg::TICK_W-1:0]  noise_limit;
	logic [pps_pkg::RANGE_W-1:0] rear_limit;
	logic [pps_pkg::LEN_W-1:0]   align_len;
	logic [pps_pkg::LEN_W-1:0]   front_len;
	logic [pps_pkg::LEN_W-1:0]   reverse_len;
	logic [pps_pkg::LEN_W-1:0]   back_len;
	pps_pkg::move_state_t        move_st;
	pps_pkg::measure_state_t     measure_st;
	logic [pps_pkg::PATH_W-1:0]  leg_start;
	logic [pps_pkg::TICK_W-1:0]  ticks;
	drive_cmd_t                  expected_cmds[$];
	int                          mismatches;

	function new();
		gap_width   = pps_pkg::RST_MIN_GAP_WIDTH;
		gap_length  = pps_pkg::RST_MIN_GAP_LENGTH;
		noise_limit = pps_pkg::RST_NOISE_TICKS;
		rear_limit  = pps_pkg::RST_REAR_SAFE_DISTANCE;
		align_len   = pps_pkg::RST_ALIGN_LENGTH;
		front_len   = pps_pkg::RST_FRONT_TURN_LENGTH;
		reverse_len = pps_pkg::RST_REVERSE_LENGTH;
		back_len    = pps_pkg::RST_BACK_TURN_LENGTH;
		move_st     = pps_pkg::MV_FORWARD;
		measure_st  = pps_pkg::MS_DETECT;
		leg_start   = '0;
		ticks       = '0;
		mismatches  = 0;
	endfunction

	function void set_reg(pps_pkg::cfg_reg_t idx, logic [pps_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			pps_pkg::REG_MIN_GAP_WIDTH:      gap_width   = val[pps_pkg::RANGE_W-1:0];
			pps_pkg::REG_MIN_GAP_LENGTH:     gap_length  = val[pps_pkg::LEN_W-1:0];
			pps_pkg::REG_NOISE_TICKS:        noise_limit = val[pps_pkg::TICK_W-1:0];
			pps_pkg::REG_REAR_SAFE_DISTANCE: rear_limit  = val[pps_pkg::RANGE_W-1:0];
			pps_pkg::REG_ALIGN_LENGTH:       align_len   = val[pps_pkg::LEN_W-1:0];
			pps_pkg::REG_FRONT_TURN_LENGTH:  front_len   = val[pps_pkg::LEN_W-1:0];
			pps_pkg::REG_REVERSE_LENGTH:     reverse_len = val[pps_pkg::LEN_W-1:0];
			pps_pkg::REG_BACK_TURN_LENGTH:   back_len    = val[pps_pkg::LEN_W-1:0];
			default: ;
		endcase
	endfunction

	function void bump_ticks();
		if (ticks != pps_pkg::TICK_MAX)
			ticks++;
	endfunction

	function void take_tick(logic signed [pps_pkg::DIST_W-1:0] side,
		logic signed [pps_pkg::DIST_W-1:0] rear, logic [pps_pkg::PATH_W-1:0] odo);
		drive_cmd_t                 cmd;
		logic [pps_pkg::PATH_W-1:0] leg_dist;
		int                         side_i;
		int                         rear_i;
		bit                         obstacle;
		side_i = side;
		rear_i = rear;
		cmd.speed = pps_pkg::SPEED_ZERO;
		cmd.steer = pps_pkg::STEER_ZERO;

		leg_dist = odo - leg_start;
		case (measure_st)
			pps_pkg::MS_DETECT: begin
				if (side_i < 0 || side_i > int'(gap_width)) begin
					measure_st = pps_pkg::MS_GAP;
					leg_start = odo;
				end
			end
			pps_pkg::MS_GAP: begin
				obstacle = side_i >= 0 && side_i < int'(gap_width);
				if (obstacle && ticks > noise_limit) begin
					measure_st = pps_pkg::MS_DETECT;
				end else if (obstacle) begin
					bump_ticks();
				end else if (leg_dist >= pps_pkg::PATH_W'(gap_length)) begin
					measure_st = pps_pkg::MS_DISABLED;
					move_st = pps_pkg::MV_ALIGN;
					leg_start = odo;
					ticks = '0;
				end
			end
			pps_pkg::MS_REAR: begin
				if (rear_i <= int'(rear_limit)) begin
					move_st = pps_pkg::MV_ADJUST;
					measure_st = pps_pkg::MS_DISABLED;
				end
			end
			default: ;
		endcase

		leg_dist = odo - leg_start;
		case (move_st)
			pps_pkg::MV_FORWARD: cmd.speed = pps_pkg::SPEED_FAST;
			pps_pkg::MV_ALIGN: begin
				if (leg_dist <= pps_pkg::PATH_W'(align_len)) begin
					cmd.speed = pps_pkg::SPEED_FAST;
				end else begin
					move_st = pps_pkg::MV_FRONTTURN;
					leg_start = odo;
				end
			end
			pps_pkg::MV_FRONTTURN: begin
				if (leg_dist <= pps_pkg::PATH_W'(front_len)) begin
					cmd.speed = pps_pkg::SPEED_TURN;
					cmd.steer = pps_pkg::STEER_TURN;
				end else begin
					move_st = pps_pkg::MV_HALT;
					leg_start = odo;
				end
			end
			pps_pkg::MV_HALT: begin
				bump_ticks();
				if (ticks >= pps_pkg::HALT_TICKS) begin
					move_st = pps_pkg::MV_REVERSE;
					leg_start = odo;
					ticks = '0;
				end
			end
			pps_pkg::MV_REVERSE: begin
				if (leg_dist <= pps_pkg::PATH_W'(reverse_len)) begin
					cmd.speed = pps_pkg::SPEED_BACK;
				end else begin
					move_st = pps_pkg::MV_BACKTURN;
					leg_start = odo;
				end
			end
			pps_pkg::MV_BACKTURN: begin
				measure_st = pps_pkg::MS_REAR;
				if (leg_dist <= pps_pkg::PATH_W'(back_len)) begin
					cmd.speed = pps_pkg::SPEED_BACK;
					cmd.steer = pps_pkg::STEER_TURN;
				end else begin
					move_st = pps_pkg::MV_ADJUST;
					measure_st = pps_pkg::MS_DISABLED;
					leg_start = odo;
				end
			end
			pps_pkg::MV_ADJUST: begin
				if (leg_dist <= pps_pkg::ADJUST_LENGTH) begin
					cmd.speed = pps_pkg::SPEED_SLOW;
				end else begin
					move_st = pps_pkg::MV_STOP;
					leg_start = odo;
				end
			end
			default: ;
		endcase

		cmd.move_phase = pps_pkg::MPHASE_W'(move_st);
		cmd.measure_phase = measure_st;
		expected_cmds.push_back(cmd);
	endfunction

	function int cmds_due();
		return expected_cmds.size();
	endfunction

	function void match_cmd(logic signed [pps_pkg::SPEED_W-1:0] speed,
		logic signed [pps_pkg::STEER_W-1:0] steer, logic [pps_pkg::MPHASE_W-1:0] mphase,
		logic [pps_pkg::SPHASE_W-1:0] sphase);
		drive_cmd_t got;
		drive_cmd_t want;
		got = '{speed, steer, mphase, sphase};
		if (expected_cmds.size() == 0) begin
			mismatches++;
			if (mismatches <= 50)
				$display("%0t: unexpected drive command: speed %0d steer %0d move %0d measure %0d",
					$time, $signed(got.speed), $signed(got.steer), got.move_phase,
					got.measure_phase);
			return;
		end
		want = expected_cmds.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 50)
				$display({"%0t: drive command mismatch: expected speed %0d steer %0d move %0d ",
					"measure %0d, actual speed %0d steer %0d move %0d measure %0d"},
					$time, $signed(want.speed), $signed(want.steer), want.move_phase,
					want.measure_phase, $signed(got.speed), $signed(got.steer),
					got.move_phase, got.measure_phase);
		end
	endfunction
endclass

module tb;
	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pps_pkg::CFG_DATA_W-1:0] cfg_data;

	pps_item_if   item_ch();
	pps_result_if result_ch();

	parallel_parking_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	maneuver_predictor          predictor;
	logic [pps_pkg::PATH_W-1:0] odo_now;
	int                         send_idle_pct = 0;
	int                         stall_pct = 0;
	bit                         hold_req = 1'b0;
	bit                         cut_backturn;

	always #4 clk = ~clk;

	initial begin
		#(8 * 400000);
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on each request
	initial begin
		int hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			predictor.match_cmd(result_ch.speed_half_units, result_ch.steering_degrees,
				result_ch.move_phase, result_ch.measure_phase);
	end

	task automatic set_mode(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 46; stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 46; end
			default:   begin send_idle_pct = 37; stall_pct = 37; end
		endcase
	endtask

	task automatic send_tick(input logic signed [pps_pkg::DIST_W-1:0] side,
		input logic signed [pps_pkg::DIST_W-1:0] rear, input logic [pps_pkg::PATH_W-1:0] odo);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.side_distance <= side;
		item_ch.rear_distance <= rear;
		item_ch.odometer <= odo;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predictor.take_tick(side, rear, odo);
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (predictor.cmds_due() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input pps_pkg::cfg_reg_t idx,
		input logic [pps_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		predictor.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [pps_pkg::RANGE_W-1:0] pick10(int hi);
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return pps_pkg::RANGE_W'($urandom_range(hi, 1));
	endfunction

	function automatic logic [pps_pkg::LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return pps_pkg::LEN_W'($urandom_range(1500, 1));
	endfunction

	// width, distance and noise values keep random upper data bits so register masking gets exercised
	function automatic logic [pps_pkg::CFG_DATA_W-1:0] pick_value(pps_pkg::cfg_reg_t idx);
		logic [pps_pkg::CFG_DATA_W-1:0] v;
		v = pps_pkg::CFG_DATA_W'($urandom);
		case (idx)
			pps_pkg::REG_MIN_GAP_WIDTH:      v[pps_pkg::RANGE_W-1:0] = pick10(200);
			pps_pkg::REG_REAR_SAFE_DISTANCE: v[pps_pkg::RANGE_W-1:0] = pick10(300);
			pps_pkg::REG_NOISE_TICKS: begin
				if ($urandom_range(3) == 0)
					v[pps_pkg::TICK_W-1:0] = $urandom_range(1) ? '0 : pps_pkg::TICK_MAX;
				else
					v[pps_pkg::TICK_W-1:0] = pps_pkg::TICK_W'($urandom_range(20));
			end
			default: v = pick_len();
		endcase
		return v;
	endfunction

	function automatic logic signed [pps_pkg::DIST_W-1:0] pick_side(int obst_pct);
		int r;
		int w;
		int neg;
		w = predictor.gap_width;
		r = $urandom_range(99);
		if (r < obst_pct && w > 0)
			return pps_pkg::DIST_W'($urandom_range(w - 1, 0));
		if (r < obst_pct + 5)
			return pps_pkg::DIST_W'(w);
		if (r < obst_pct + 10)
			return pps_pkg::DIST_W'($urandom);
		if (w == 1023 || $urandom_range(1)) begin
			neg = -int'($urandom_range(1024, 1));
			return pps_pkg::DIST_W'(neg);
		end
		return pps_pkg::DIST_W'($urandom_range(1023, w + 1));
	endfunction

	function automatic logic signed [pps_pkg::DIST_W-1:0] pick_rear();
		int lim;
		int neg;
		lim = predictor.rear_limit;
		if (predictor.move_st == pps_pkg::MV_BACKTURN && cut_backturn &&
			$urandom_range(7) == 0) begin
			neg = -1;
			return pps_pkg::DIST_W'($urandom_range(1) ? neg : int'($urandom_range(lim, 0)));
		end
		if ($urandom_range(49) == 0 || lim == 1023)
			return pps_pkg::DIST_W'($urandom);
		return pps_pkg::DIST_W'($urandom_range(1023, lim + 1));
	endfunction

	function automatic int leg_span();
		if (predictor.measure_st == pps_pkg::MS_GAP)
			return predictor.gap_length;
		case (predictor.move_st)
			pps_pkg::MV_ALIGN:     return predictor.align_len;
			pps_pkg::MV_FRONTTURN: return predictor.front_len;
			pps_pkg::MV_REVERSE:   return predictor.reverse_len;
			pps_pkg::MV_BACKTURN:  return predictor.back_len;
			pps_pkg::MV_ADJUST:    return pps_pkg::ADJUST_LENGTH;
			default:               return 64;
		endcase
	endfunction

	task automatic run_search(int n, int obst_pct);
		repeat (n) begin
			if ($urandom_range(99) == 0)
				odo_now += pps_pkg::PATH_W'($urandom_range(2000, 0));
			else
				odo_now += pps_pkg::PATH_W'($urandom_range(8, 0));
			send_tick(pick_side(obst_pct), pps_pkg::DIST_W'($urandom), odo_now);
		end
	endtask

	// odometer step scaled to the current leg so each leg spans a few dozen ticks
	task automatic maneuver_tick();
		int span;
		if (predictor.move_st == pps_pkg::MV_STOP) begin
			send_tick(pps_pkg::DIST_W'($urandom), pps_pkg::DIST_W'($urandom),
				pps_pkg::PATH_W'($urandom));
		end else begin
			span = leg_span();
			odo_now += pps_pkg::PATH_W'($urandom_range(span / 15 + 1, 0));
			send_tick(pick_side(predictor.measure_st == pps_pkg::MS_GAP ? 2 : 20), pick_rear(),
				odo_now);
		end
	endtask

	initial begin
		int                waited;
		pps_pkg::cfg_reg_t idx;
		predictor = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.side_distance <= '0;
		item_ch.rear_distance <= '0;
		item_ch.odometer <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gap search corner cases under reset settings
		set_mode(IDLE_NONE);
		send_tick(11'sd25, 11'sd1023, 24'd0);
		send_tick(11'sd0, 11'h400, 24'd10);
		send_tick(11'sd26, -11'sd1, 24'd20);
		send_tick(11'sd25, 11'sd0, 24'd30);
		send_tick(11'sd0, 11'sd3, 24'd40);
		send_tick(11'sd24, 11'sd4, 24'd50);
		send_tick(11'sd1, 11'sd1023, 24'd60);
		send_tick(11'sd5, 11'sd0, 24'd70);
		send_tick(-11'sd1, 11'h400, 24'd80);
		send_tick(11'sd0, -11'sd1, 24'd90);
		send_tick(11'h400, 11'sd2, 24'hFFFFFF);
		send_tick(11'sd1023, 11'sd1023, 24'h000100);
		send_tick(11'sd25, 11'h400, 24'h0002FE);
		send_tick(11'sd7, 11'sd0, 24'h0002FE);
		send_tick(11'sd1023, -11'sd1, 24'd0);
		send_tick(11'sd0, 11'sd1023, 24'd0);
		odo_now = 24'h000300;

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			set_mode(idle_mode_t'(ph % 4));
			write_reg(pps_pkg::REG_MIN_GAP_LENGTH, 16'hFFFF);
			write_reg(pps_pkg::REG_MIN_GAP_WIDTH, ph == 1 ? 16'd0 : ph == 2 ? 16'd1023 :
				pick_value(pps_pkg::REG_MIN_GAP_WIDTH));
			write_reg(pps_pkg::REG_NOISE_TICKS, ph == 7 ? 16'd255 : ph == 1 ? 16'd0 :
				16'($urandom_range(20)));
			if (ph == 4) begin
				odo_now = 24'hFFFE00;
				hold_req = 1'b1;
			end
			if (ph == 7)
				run_search(320, 85);
			else
				run_search(90, 40);
		end

		wait_idle();
		for (int i = 0; i < 8; i++) begin
			idx = pps_pkg::cfg_reg_t'(i);
			write_reg(idx, pick_value(idx));
		end
		cut_backturn = 1'($urandom_range(1));
		for (int k = 0; k < 14; k++) begin
			set_mode(idle_mode_t'(k % 4));
			if (k == 2)
				hold_req = 1'b1;
			repeat (60) maneuver_tick();
			wait_idle();
			idx = pps_pkg::cfg_reg_t'($urandom_range(7));
			write_reg(idx, pick_value(idx));
		end

		item_ch.valid <= 1'b0;
		waited = 0;
		while (predictor.cmds_due() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (predictor.cmds_due() != 0) begin
			$display("%0t: %0d drive commands never arrived", $time, predictor.cmds_due());
			predictor.mismatches++;
		end
		if (predictor.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
